// ===== design/assert_macros.svh =====
// Assertion macros for the checker module of this project.
// Self-contained; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/led_pkg.sv =====
// Package for the LED blink and pulse controller: item codes, register
// indexes, field widths and register limits. No dependencies.
package led_pkg;

   // Field widths.
   localparam int unsigned ModeW    = 3;
   localparam int unsigned ElapsedW = 16;
   localparam int unsigned PeriodW  = 16;
   localparam int unsigned TotalW   = 10;
   localparam int unsigned AccW     = 17;
   localparam int unsigned CsrAddrW = 2;
   localparam int unsigned CsrDataW = 16;
   localparam int unsigned RspDataW = 8;

   // Item kinds carried in req_tuser.
   typedef enum logic [ModeW-1:0] {
      MODE_TICK  = 3'd0,
      MODE_ON    = 3'd1,
      MODE_OFF   = 3'd2,
      MODE_BLINK = 3'd3,
      MODE_PULSE = 3'd4
   } mode_type;

   // Register indexes on the csr port.
   typedef enum logic [CsrAddrW-1:0] {
      REG_BLINK_PERIOD = 2'd0,
      REG_PULSE_TOTAL  = 2'd1,
      REG_ACTIVE_LOW   = 2'd2
   } reg_index_type;

   // Register reset values and accepted ranges.
   localparam logic [PeriodW-1:0] PERIOD_RESET = 16'd500;
   localparam logic [PeriodW-1:0] PERIOD_MIN   = 16'd200;
   localparam logic [PeriodW-1:0] PERIOD_LIMIT = 16'd60000;
   localparam logic [TotalW-1:0]  TOTAL_RESET  = 10'd5;
   localparam logic [TotalW-1:0]  TOTAL_LIMIT  = 10'd1000;

endpackage

// ===== design/led_blink_pulse_controller.sv =====
// LED blink and pulse controller, top level.
// Uses led_pkg for codes, widths and register limits.
//
// Use: each item on the req_ channel is a tick (req_tuser = tick, req_tdata =
// elapsed milliseconds) or a command (steady on, steady off, start blink,
// start pulse). Every item yields exactly one item on the rsp_ channel that
// reports the LED state after it: led_lit, pin_level, blinking, pulsing.
// Blink period, pulse count and pin polarity are set through the csr_ port;
// the user must write them only while the block is idle, as the block does
// not enforce this itself. Out-of-range values are dropped. The result is
// registered: the update runs between the input register and the result
// register. Throughput is one item per cycle while the receiver does not
// stall; the accumulator, the flash counter and the mode flags are updated
// together for each item.
// When the receiver stalls, the result register holds and the input register
// still takes one more item; after that req_tready falls until rsp_tready
// returns. Reset clears both valid flags and the LED and mode state, and
// loads the register defaults (500 ms period, 5 flashes, active-high pin).
module led_blink_pulse_controller (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] elapsed
   input  logic [2:0]  req_tuser,   // [2:0] mode
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] led_lit, [1] pin_level, [2] blinking,
                                    // [3] pulsing, [7:4] zero
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // Configuration registers.
   logic [led_pkg::PeriodW-1:0] period_ff;
   logic [led_pkg::TotalW-1:0]  total_ff;
   logic                        active_low_ff;

   // Input register.
   logic                         s1_valid_ff, s1_valid_in;
   logic [led_pkg::ModeW-1:0]    s1_mode_ff;
   logic [led_pkg::ElapsedW-1:0] s1_elapsed_ff;

   // LED state.
   logic                      lit_ff, lit_in;
   logic                      blink_ff, blink_in;
   logic                      pulse_ff, pulse_in;
   logic [led_pkg::AccW-1:0]  acc_ff, acc_in;
   logic [led_pkg::TotalW-1:0] flashes_ff, flashes_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [led_pkg::RspDataW-1:0] rsp_data_ff, rsp_data_in;

   logic                     advance;
   logic                     req_take;
   logic                     do_step;
   logic [led_pkg::AccW-1:0] acc_sum;
   logic                     expired;
   logic [led_pkg::TotalW-1:0] csr_total;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign do_step    = s1_valid_ff && advance;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = do_step || (rsp_valid_ff && !rsp_tready);

   // The accumulator never exceeds the period before a tick, so 17 bits hold the sum.
   assign acc_sum = acc_ff + {1'b0, s1_elapsed_ff};
   assign expired = acc_sum > {1'b0, period_ff};

   assign csr_total = csr_wdata[led_pkg::TotalW-1:0];

   always_comb begin
      lit_in     = lit_ff;
      blink_in   = blink_ff;
      pulse_in   = pulse_ff;
      acc_in     = acc_ff;
      flashes_in = flashes_ff;
      case (s1_mode_ff)
         led_pkg::MODE_TICK: begin
            if (pulse_ff) begin
               acc_in = acc_sum;
               if (expired) begin
                  acc_in = '0;
                  if (flashes_ff < total_ff) begin
                     if (lit_ff) begin
                        lit_in = 1'b0;
                     end else begin
                        lit_in     = 1'b1;
                        flashes_in = flashes_ff + 1'b1;
                     end
                  end else begin
                     // Last flash done: the sequence ends with the LED off.
                     flashes_in = '0;
                     lit_in     = 1'b0;
                     blink_in   = 1'b0;
                     pulse_in   = 1'b0;
                  end
               end
            end else if (blink_ff) begin
               acc_in = acc_sum;
               if (expired) begin
                  acc_in = '0;
                  lit_in = !lit_ff;
               end
            end
         end
         led_pkg::MODE_ON: begin
            lit_in   = 1'b1;
            blink_in = 1'b0;
            pulse_in = 1'b0;
         end
         led_pkg::MODE_OFF: begin
            lit_in   = 1'b0;
            blink_in = 1'b0;
            pulse_in = 1'b0;
         end
         led_pkg::MODE_BLINK: begin
            if (!blink_ff) begin
               blink_in = 1'b1;
               pulse_in = 1'b0;
               acc_in   = '0;
               lit_in   = 1'b0;
            end
         end
         led_pkg::MODE_PULSE: begin
            if (!pulse_ff) begin
               flashes_in = '0;
               pulse_in   = 1'b1;
               blink_in   = 1'b0;
               acc_in     = '0;
               lit_in     = 1'b0;
            end
         end
         default: begin
         end
      endcase
      rsp_data_in = {4'b0000, pulse_in, blink_in, lit_in ^ active_low_ff, lit_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff     <= led_pkg::PERIOD_RESET;
         total_ff      <= led_pkg::TOTAL_RESET;
         active_low_ff <= 1'b0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         lit_ff        <= 1'b0;
         blink_ff      <= 1'b0;
         pulse_ff      <= 1'b0;
         acc_ff        <= '0;
         flashes_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (do_step) begin
            lit_ff     <= lit_in;
            blink_ff   <= blink_in;
            pulse_ff   <= pulse_in;
            acc_ff     <= acc_in;
            flashes_ff <= flashes_in;
         end
         if (csr_we) begin
            case (csr_addr)
               led_pkg::REG_BLINK_PERIOD: begin
                  if (csr_wdata >= led_pkg::PERIOD_MIN && csr_wdata < led_pkg::PERIOD_LIMIT) begin
                     period_ff <= csr_wdata;
                  end
               end
               led_pkg::REG_PULSE_TOTAL: begin
                  if (csr_total != '0 && csr_total < led_pkg::TOTAL_LIMIT) begin
                     total_ff <= csr_total;
                  end
               end
               led_pkg::REG_ACTIVE_LOW: begin
                  active_low_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_mode_ff    <= req_tuser;
         s1_elapsed_ff <= req_tdata;
      end
      if (do_step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== design/led_chk.sv =====
// Port-level checker for the LED blink and pulse controller, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module led_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   logic stalled;
   logic both_modes;

   assign stalled    = rsp_tvalid && !rsp_tready;
   assign both_modes = rsp_tdata[2] && rsp_tdata[3];

   // A stalled result stays offered and keeps its value.
   `ASSERT_CLK_RST(a_valid_hold, clock, reset, stalled |=> rsp_tvalid, "held item dropped")
   `ASSERT_CLK_RST(a_data_hold, clock, reset, stalled |=> $stable(rsp_tdata), "held data changed")

   // Blink and pulse modes are never reported together.
   `ASSERT_CLK_RST(a_modes_excl, clock, reset, rsp_tvalid |-> !both_modes, "both modes active")

   // Nothing is offered in the cycle after reset.
   `ASSERT_CLK(a_reset_idle, clock, reset |=> !rsp_tvalid, "result valid right after reset")

   // With the result side free, the block always has room for an item.
   `ASSERT_CLK_RST(a_ready_free, clock, reset, !rsp_tvalid |-> req_tready, "stall with empty output")

endmodule

bind led_blink_pulse_controller led_chk u_led_chk (.*);
